>>> rtl/pts_pkg.sv
// Package of shared constants, command codes and task states for the priority task scheduler.
`default_nettype none
package pts_pkg;
   localparam int unsigned TASKS = 16;
   localparam int unsigned PRIOS = 32;
   localparam int unsigned IDW   = 5;
   localparam int unsigned TW    = 4;
   localparam int unsigned LW    = 5;
   localparam logic [IDW-1:0] NIL = IDW'(TASKS);

   typedef enum logic [3:0] {
      FN_CREATE  = 4'd0,
      FN_DELETE  = 4'd1,
      FN_SUSPEND = 4'd2,
      FN_RESUME  = 4'd3,
      FN_YIELD   = 4'd4,
      FN_DELAY   = 4'd5,
      FN_SETPRIO = 4'd6,
      FN_TICK    = 4'd7,
      FN_LOCK    = 4'd8,
      FN_UNLOCK  = 4'd9,
      FN_IRQIN   = 4'd10,
      FN_IRQOUT  = 4'd11,
      FN_START   = 4'd12
   } func_type;

   typedef enum logic [2:0] {
      ST_UNUSED     = 3'd0,
      ST_READY      = 3'd1,
      ST_RUNNING    = 3'd2,
      ST_SLEEPING   = 3'd3,
      ST_SUSPENDED  = 3'd4,
      ST_TERMINATED = 3'd5
   } task_state_type;

   localparam logic RSP_OK  = 1'b0;
   localparam logic RSP_BAD = 1'b1;
endpackage
`default_nettype wire

>>> rtl/pts_pick.sv
// Priority encoder that finds the most urgent non-empty ready queue.
`default_nettype none
module pts_pick (
   input  wire logic [pts_pkg::PRIOS-1:0] mask,
   output logic                           found,
   output logic [pts_pkg::LW-1:0]         level
);
   always_comb begin
      found = 1'b0;
      level = '0;
      for (int i = pts_pkg::PRIOS - 1; i >= 0; i--) begin
         if (mask[i]) begin
            found = 1'b1;
            level = pts_pkg::LW'(i);
         end
      end
   end
endmodule
`default_nettype wire

>>> rtl/priority_task_scheduler_top.sv
// Top level of the priority task scheduler: command sequencer, task tables and ready queues.
//
//  channel | direction | handshake            | payload
//  req     | in        | req_tvalid/tready    | tuser func, tdata task_id,new_prio,delay_ticks
//  rsp     | out       | rsp_tvalid/tready    | tdata status,running_task,switched,tick_now
//  csr     | in        | csr_valid/csr_ready  | csr_wdata slice_reload
//
// Each command runs through the sequencer states before the next is accepted; a tick adds
// the slot-by-slot wakeup scan through the single queue update unit.
// Reset is synchronous and clears all task slots and queues at once.
// The block takes no new transaction until the result of the last one is loaded into
// the output register; a stalled result holds there.
`default_nettype none
module priority_task_scheduler_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [3:0]  req_tuser,   // func
   input  wire logic [47:0] req_tdata,   // task_id[4:0], new_prio[12:5], delay_ticks[44:13]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [39:0]      rsp_tdata,   // status[0], running_task[5:1], switched[6], tick_now[38:7]
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [15:0] csr_wdata
);
   localparam int unsigned T  = pts_pkg::TASKS;
   localparam int unsigned P  = pts_pkg::PRIOS;
   localparam int unsigned IW = pts_pkg::IDW;
   localparam int unsigned TW = pts_pkg::TW;
   localparam int unsigned LW = pts_pkg::LW;
   localparam logic [IW-1:0] NIL = pts_pkg::NIL;

   typedef enum logic [3:0] {
      S_IDLE, S_CMD, S_APP, S_SCAN, S_SLICE, S_RESCHED, S_RS2, S_START2, S_OUT
   } seq_type;

   seq_type state_ff;

   logic [2:0]    status_ff [T];
   logic [LW-1:0] level_ff  [T];
   logic [LW-1:0] base_ff   [T];
   logic [31:0]   wake_ff   [T];
   logic [15:0]   slice_ff  [T];
   logic [IW-1:0] next_ff   [T];
   logic [IW-1:0] prev_ff   [T];
   logic [IW-1:0] head_ff   [P];
   logic [IW-1:0] tail_ff   [P];
   logic [IW-1:0] len_ff    [P];
   logic [P-1:0]  mask_ff;
   logic [IW-1:0] run_ff;
   logic [31:0]   tick_ff;
   logic [7:0]    lock_ff;
   logic [7:0]    irq_ff;
   logic          pend_ff;
   logic          started_ff;
   logic [15:0]   reload_ff;

   logic [3:0]    func_ff;
   logic [IW-1:0] id_ff;
   logic [7:0]    prio_ff;
   logic [31:0]   ticks_ff;
   logic          bad_ff;
   logic          sw_ff;
   logic [IW-1:0] tgt_ff;
   logic          do_rs_ff;
   logic [TW-1:0] scan_ff;
   logic          rsp_valid_ff;
   logic [39:0]   rsp_data_ff;

   logic          pick_found;
   logic [LW-1:0] pick_level;
   logic [IW-1:0] pick_id;

   pts_pick u_pick (.mask(mask_ff), .found(pick_found), .level(pick_level));
   assign pick_id = pick_found ? head_ff[pick_level] : NIL;

   // command decode
   logic          id_ok;
   logic [IW-1:0] eid;
   logic [TW-1:0] ei;
   logic [TW-1:0] ri;
   logic          live;
   logic          prio_ok;
   logic          yield_ok;
   logic          sp_change;
   logic          create_ok;
   logic [31:0]   wake_diff;

   always_comb begin
      ri        = run_ff[TW-1:0];
      id_ok     = id_ff < NIL;
      eid       = (func_ff == pts_pkg::FN_DELETE && id_ff == NIL) ? run_ff : id_ff;
      ei        = eid[TW-1:0];
      if (func_ff == pts_pkg::FN_DELETE && id_ff == NIL) begin
         live = run_ff < NIL;
      end else begin
         live = id_ok && status_ff[ei] != pts_pkg::ST_UNUSED;
      end
      prio_ok   = prio_ff < 8'(P);
      yield_ok  = run_ff != NIL && status_ff[ri] == pts_pkg::ST_RUNNING &&
                  len_ff[level_ff[ri]] != '0;
      sp_change = !(level_ff[ei] == prio_ff[LW-1:0] && base_ff[ei] == prio_ff[LW-1:0]);
      create_ok = id_ok && prio_ok &&
                  (status_ff[ei] == pts_pkg::ST_UNUSED ||
                   (status_ff[ei] == pts_pkg::ST_TERMINATED && id_ff != run_ff));
      wake_diff = tick_ff - wake_ff[scan_ff];
   end

   // shared queue update unit: one unlink or one append per cycle
   logic          rm_en;
   logic [IW-1:0] rm_t;
   logic          ap_en;
   logic [IW-1:0] ap_t;

   always_comb begin
      rm_en = 1'b0;
      rm_t  = eid;
      ap_en = 1'b0;
      ap_t  = tgt_ff;
      case (state_ff)
         S_CMD: begin
            case (func_ff)
               pts_pkg::FN_DELETE, pts_pkg::FN_SUSPEND: begin
                  rm_en = live && status_ff[ei] == pts_pkg::ST_READY;
               end
               pts_pkg::FN_SETPRIO: begin
                  rm_en = live && prio_ok && sp_change && status_ff[ei] == pts_pkg::ST_READY;
               end
               pts_pkg::FN_YIELD: begin
                  ap_en = yield_ok;
                  ap_t  = run_ff;
               end
               pts_pkg::FN_DELAY: begin
                  if (ticks_ff == '0) begin
                     ap_en = yield_ok;
                     ap_t  = run_ff;
                  end else begin
                     rm_en = run_ff != NIL && status_ff[ri] == pts_pkg::ST_READY;
                     rm_t  = run_ff;
                  end
               end
               default: begin
                  rm_en = 1'b0;
               end
            endcase
         end
         S_APP: begin
            ap_en = 1'b1;
         end
         S_SCAN: begin
            ap_en = status_ff[scan_ff] == pts_pkg::ST_SLEEPING && !wake_diff[31];
            ap_t  = {1'b0, scan_ff};
         end
         S_RS2, S_START2: begin
            rm_en = tgt_ff != NIL;
            rm_t  = tgt_ff;
         end
         default: begin
            rm_en = 1'b0;
         end
      endcase
   end

   logic [TW-1:0] rm_i;
   logic [LW-1:0] rm_lv;
   logic [IW-1:0] rm_p;
   logic [IW-1:0] rm_n;
   logic [IW-1:0] rm_len;
   logic [TW-1:0] ap_i;
   logic [LW-1:0] ap_lv;
   logic [IW-1:0] ap_tl;

   always_comb begin
      rm_i   = rm_t[TW-1:0];
      rm_lv  = level_ff[rm_i];
      rm_p   = prev_ff[rm_i];
      rm_n   = next_ff[rm_i];
      rm_len = (len_ff[rm_lv] != '0) ? len_ff[rm_lv] - 1'b1 : len_ff[rm_lv];
      ap_i   = ap_t[TW-1:0];
      ap_lv  = level_ff[ap_i];
      ap_tl  = tail_ff[ap_lv];
   end

   assign req_tready = state_ff == S_IDLE;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         for (int i = 0; i < T; i++) begin
            status_ff[i] <= pts_pkg::ST_UNUSED;
            level_ff[i]  <= '0;
            base_ff[i]   <= '0;
            wake_ff[i]   <= '0;
            slice_ff[i]  <= '0;
         end
         for (int i = 0; i < P; i++) begin
            head_ff[i] <= NIL;
            tail_ff[i] <= NIL;
            len_ff[i]  <= '0;
         end
         mask_ff      <= '0;
         run_ff       <= NIL;
         tick_ff      <= '0;
         lock_ff      <= '0;
         irq_ff       <= '0;
         pend_ff      <= 1'b0;
         started_ff   <= 1'b0;
         reload_ff    <= 16'd10;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            reload_ff <= csr_wdata;
         end
         if (rsp_tready && state_ff != S_OUT) begin
            rsp_valid_ff <= 1'b0;
         end
         if (rm_en) begin
            if (rm_p != NIL) next_ff[rm_p[TW-1:0]] <= rm_n;
            else head_ff[rm_lv] <= rm_n;
            if (rm_n != NIL) prev_ff[rm_n[TW-1:0]] <= rm_p;
            else tail_ff[rm_lv] <= rm_p;
            next_ff[rm_i] <= NIL;
            prev_ff[rm_i] <= NIL;
            len_ff[rm_lv] <= rm_len;
            if (rm_len == '0) mask_ff[rm_lv] <= 1'b0;
         end
         if (ap_en) begin
            next_ff[ap_i] <= NIL;
            prev_ff[ap_i] <= ap_tl;
            if (ap_tl != NIL) next_ff[ap_tl[TW-1:0]] <= ap_t;
            else head_ff[ap_lv] <= ap_t;
            tail_ff[ap_lv]   <= ap_t;
            len_ff[ap_lv]    <= len_ff[ap_lv] + 1'b1;
            mask_ff[ap_lv]   <= 1'b1;
            status_ff[ap_i]  <= pts_pkg::ST_READY;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_tvalid) begin
                  func_ff  <= req_tuser;
                  id_ff    <= req_tdata[4:0];
                  prio_ff  <= req_tdata[12:5];
                  ticks_ff <= req_tdata[44:13];
                  bad_ff   <= pts_pkg::RSP_OK;
                  sw_ff    <= 1'b0;
                  state_ff <= S_CMD;
               end
            end
            S_CMD: begin
               state_ff <= S_OUT;
               case (func_ff)
                  pts_pkg::FN_CREATE: begin
                     if (!create_ok) begin
                        bad_ff <= pts_pkg::RSP_BAD;
                     end else begin
                        level_ff[ei] <= prio_ff[LW-1:0];
                        base_ff[ei]  <= prio_ff[LW-1:0];
                        slice_ff[ei] <= reload_ff;
                        tgt_ff       <= id_ff;
                        do_rs_ff     <= 1'b1;
                        state_ff     <= S_APP;
                     end
                  end
                  pts_pkg::FN_DELETE, pts_pkg::FN_SUSPEND: begin
                     if (!live) begin
                        bad_ff <= pts_pkg::RSP_BAD;
                     end else begin
                        status_ff[ei] <= (func_ff == pts_pkg::FN_DELETE) ?
                                         pts_pkg::ST_TERMINATED : pts_pkg::ST_SUSPENDED;
                        if (eid == run_ff) state_ff <= S_RESCHED;
                     end
                  end
                  pts_pkg::FN_RESUME: begin
                     if (!live) begin
                        bad_ff <= pts_pkg::RSP_BAD;
                     end else if (status_ff[ei] == pts_pkg::ST_SUSPENDED) begin
                        tgt_ff   <= id_ff;
                        do_rs_ff <= 1'b1;
                        state_ff <= S_APP;
                     end else begin
                        state_ff <= S_RESCHED;
                     end
                  end
                  pts_pkg::FN_YIELD: begin
                     if (yield_ok) state_ff <= S_RESCHED;
                  end
                  pts_pkg::FN_DELAY: begin
                     if (ticks_ff == '0) begin
                        if (yield_ok) state_ff <= S_RESCHED;
                     end else if (run_ff == NIL) begin
                        bad_ff <= pts_pkg::RSP_BAD;
                     end else begin
                        wake_ff[ri]   <= tick_ff + ticks_ff;
                        status_ff[ri] <= pts_pkg::ST_SLEEPING;
                        state_ff      <= S_RESCHED;
                     end
                  end
                  pts_pkg::FN_SETPRIO: begin
                     if (!live || !prio_ok) begin
                        bad_ff <= pts_pkg::RSP_BAD;
                     end else if (sp_change) begin
                        if (level_ff[ei] == base_ff[ei] || prio_ff[LW-1:0] < level_ff[ei]) begin
                           level_ff[ei] <= prio_ff[LW-1:0];
                        end
                        base_ff[ei] <= prio_ff[LW-1:0];
                        if (status_ff[ei] == pts_pkg::ST_READY) begin
                           tgt_ff   <= id_ff;
                           do_rs_ff <= 1'b1;
                           state_ff <= S_APP;
                        end else begin
                           state_ff <= S_RESCHED;
                        end
                     end
                  end
                  pts_pkg::FN_TICK: begin
                     tick_ff  <= tick_ff + 1'b1;
                     scan_ff  <= '0;
                     state_ff <= S_SCAN;
                  end
                  pts_pkg::FN_LOCK: begin
                     if (lock_ff != 8'hFF) lock_ff <= lock_ff + 1'b1;
                  end
                  pts_pkg::FN_UNLOCK: begin
                     if (lock_ff != '0) begin
                        lock_ff <= lock_ff - 1'b1;
                        if (lock_ff == 8'd1 && pend_ff) state_ff <= S_RESCHED;
                     end
                  end
                  pts_pkg::FN_IRQIN: begin
                     if (irq_ff != 8'hFF) irq_ff <= irq_ff + 1'b1;
                  end
                  pts_pkg::FN_IRQOUT: begin
                     if (irq_ff != '0) begin
                        irq_ff <= irq_ff - 1'b1;
                        if (lock_ff == '0 && irq_ff == 8'd1 && pend_ff) state_ff <= S_RESCHED;
                     end
                  end
                  pts_pkg::FN_START: begin
                     if (started_ff) begin
                        bad_ff <= pts_pkg::RSP_BAD;
                     end else begin
                        started_ff <= 1'b1;
                        sw_ff      <= 1'b1;
                        tgt_ff     <= pick_id;
                        state_ff   <= S_START2;
                     end
                  end
                  default: begin
                     bad_ff <= pts_pkg::RSP_BAD;
                  end
               endcase
            end
            S_APP: begin
               state_ff <= do_rs_ff ? S_RESCHED : S_OUT;
            end
            S_SCAN: begin
               scan_ff <= scan_ff + 1'b1;
               if (scan_ff == TW'(T - 1)) state_ff <= S_SLICE;
            end
            S_SLICE: begin
               state_ff <= S_RESCHED;
               if (run_ff != NIL && status_ff[ri] == pts_pkg::ST_RUNNING &&
                   slice_ff[ri] != '0) begin
                  if (slice_ff[ri] == 16'd1) begin
                     slice_ff[ri] <= reload_ff;
                     if (len_ff[level_ff[ri]] != '0) begin
                        tgt_ff   <= run_ff;
                        do_rs_ff <= 1'b1;
                        state_ff <= S_APP;
                     end
                  end else begin
                     slice_ff[ri] <= slice_ff[ri] - 1'b1;
                  end
               end
            end
            S_RESCHED: begin
               state_ff <= S_OUT;
               if (started_ff) begin
                  if (lock_ff != '0 || irq_ff != '0) begin
                     pend_ff <= 1'b1;
                  end else begin
                     pend_ff  <= 1'b0;
                     tgt_ff   <= pick_id;
                     state_ff <= S_RS2;
                  end
               end
            end
            S_RS2: begin
               state_ff <= S_OUT;
               if (tgt_ff != NIL) status_ff[tgt_ff[TW-1:0]] <= pts_pkg::ST_RUNNING;
               if (tgt_ff != run_ff) begin
                  run_ff <= tgt_ff;
                  sw_ff  <= 1'b1;
                  if (run_ff != NIL && status_ff[ri] == pts_pkg::ST_RUNNING) begin
                     tgt_ff   <= run_ff;
                     do_rs_ff <= 1'b0;
                     state_ff <= S_APP;
                  end
               end
            end
            S_START2: begin
               if (tgt_ff != NIL) status_ff[tgt_ff[TW-1:0]] <= pts_pkg::ST_RUNNING;
               run_ff   <= tgt_ff;
               state_ff <= S_OUT;
            end
            S_OUT: begin
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff  <= {1'b0, tick_ff, sw_ff, run_ff, bad_ff};
                  state_ff     <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   a_run_range: assert property (@(posedge clock) disable iff (reset)
      run_ff <= NIL) else $error("running task out of range");
   a_started_sticks: assert property (@(posedge clock) disable iff (reset)
      started_ff |=> started_ff) else $error("start flag cleared");
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready) else $error("accepted while busy");
   a_idle_before_start: assert property (@(posedge clock) disable iff (reset)
      !started_ff |-> run_ff == NIL) else $error("task running before start");
endmodule
`default_nettype wire
